>>> hw/rtl/gcsd_pkg.sv
// ----------------------------------------------------------------------------
// gcsd_pkg
// Shared types, constants and decode tables for the command stream deframer.
// ----------------------------------------------------------------------------
package gcsd_pkg;

	localparam int unsigned WordW     = 32;
	localparam int unsigned IndexW    = 9;
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
	localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

	localparam logic [2:0] TYPE_MI     = 3'd0;
	localparam logic [2:0] TYPE_RSVD1  = 3'd1;
	localparam logic [2:0] TYPE_RSVD2  = 3'd2;
	localparam logic [2:0] TYPE_RENDER = 3'd3;

	localparam logic [5:0] MI_OP_NOOP       = 6'd0;
	localparam logic [5:0] MI_OP_BATCH_END  = 6'd10;
	localparam logic [5:0] MI_OP_LOAD_IMM   = 6'd26;
	localparam logic [5:0] MI_OP_LOAD_MEM   = 6'd34;
	localparam logic [5:0] MI_OP_LOAD_REG   = 6'd41;
	localparam logic [5:0] MI_OP_STORE_MEM  = 6'd47;
	localparam logic [5:0] MI_OP_BATCH_START = 6'd49;
	localparam logic [5:0] MI_OP_LONG_FIRST = 6'd16;

	localparam logic [1:0] RSUB_COMMON   = 2'd0;
	localparam logic [1:0] RSUB_SINGLE   = 2'd1;
	localparam logic [1:0] RSUB_RESERVED = 2'd2;
	localparam logic [1:0] RSUB_3D       = 2'd3;

	// render opcodes, bits 26..24 of a render header
	localparam logic [2:0] RENDER_OP_STATE = 3'd0;
	localparam logic [2:0] RENDER_OP_CTRL  = 3'd1;
	localparam logic [2:0] RENDER_OP_PRIM  = 3'd2;
	localparam logic [2:0] RENDER_OP_EXT   = 3'd3;

	localparam logic [7:0] SUBOP_SELECT_PIPE = 8'd11;
	localparam logic [7:0] SUBOP_COMMON_MAX  = 8'd4;
	localparam logic [7:0] SUBOP_SINGLE_CTRL = 8'd4;

	// pipelined 3D state subopcodes with an action, bit n = subopcode n
	localparam logic [127:0] PipeSet = {64'h0000_0000_0007_FEF8, 64'hFFFF_FFDB_FFFF_F7F0};

	typedef enum logic [1:0] {
		ST_HANDLED   = 2'd0,
		ST_UNHANDLED = 2'd1,
		ST_ILLEGAL   = 2'd2,
		ST_UNKNOWN   = 2'd3
	} status_t;

	// header decode of a word, as if it were a header
	typedef struct packed {
		logic [2:0]        cmd_type;
		logic [1:0]        cmd_subtype;
		logic [5:0]        cmd_opcode;
		logic [7:0]        cmd_subopcode;
		status_t           status;
		logic [IndexW-1:0] len_m1;
		logic              batch_end;
	} hdr_t;

	typedef struct packed {
		logic [WordW-1:0] word;
		hdr_t             hdr;
	} entry_t;

	function automatic logic mi_known(input logic [5:0] op);
		mi_known = (op == MI_OP_NOOP) || (op == MI_OP_BATCH_END) ||
			(op == MI_OP_LOAD_IMM) || (op == MI_OP_LOAD_MEM) ||
			(op == MI_OP_LOAD_REG) || (op == MI_OP_STORE_MEM) ||
			(op == MI_OP_BATCH_START);
	endfunction

	function automatic logic pipe_known(input logic [7:0] subop);
		pipe_known = !subop[7] && PipeSet[subop[6:0]];
	endfunction

endpackage

>>> hw/rtl/gcsd_front.sv
// ----------------------------------------------------------------------------
// gcsd_front
// Header decode of an incoming word: fields, status, length and batch end.
// ----------------------------------------------------------------------------
module gcsd_front (
	input  logic [gcsd_pkg::WordW-1:0] word,
	output gcsd_pkg::hdr_t             hdr
);

	logic [2:0]                 typ;
	logic [1:0]                 sub;
	logic [2:0]                 rop;
	logic [7:0]                 subop;
	logic [5:0]                 miop;
	logic [gcsd_pkg::IndexW-1:0] len_field;

	assign typ       = word[31:29];
	assign sub       = word[28:27];
	assign rop       = word[26:24];
	assign subop     = word[23:16];
	assign miop      = word[28:23];
	// length field plus 2, less one
	assign len_field = {1'b0, word[7:0]} + gcsd_pkg::IndexW'(1);

	always_comb begin
		hdr = '{
			cmd_type:      typ,
			cmd_subtype:   2'd0,
			cmd_opcode:    6'd0,
			cmd_subopcode: 8'd0,
			status:        gcsd_pkg::ST_UNKNOWN,
			len_m1:        len_field,
			batch_end:     1'b0
		};
		case (typ)
			gcsd_pkg::TYPE_MI: begin
				hdr.cmd_opcode = miop;
				hdr.status     = gcsd_pkg::mi_known(miop) ? gcsd_pkg::ST_HANDLED
					: gcsd_pkg::ST_UNHANDLED;
				hdr.batch_end  = (miop == gcsd_pkg::MI_OP_BATCH_END);
				if (miop < gcsd_pkg::MI_OP_LONG_FIRST) begin
					hdr.len_m1 = '0;
				end
			end
			gcsd_pkg::TYPE_RSVD1, gcsd_pkg::TYPE_RSVD2: begin
				hdr.len_m1 = '0;
			end
			gcsd_pkg::TYPE_RENDER: begin
				hdr.cmd_subtype   = sub;
				hdr.cmd_opcode    = {3'd0, rop};
				hdr.cmd_subopcode = subop;
				case (sub)
					gcsd_pkg::RSUB_COMMON: begin
						if (rop == gcsd_pkg::RENDER_OP_STATE) begin
							hdr.status = gcsd_pkg::ST_HANDLED;
						end else if (rop == gcsd_pkg::RENDER_OP_CTRL) begin
							hdr.status = (subop >= 8'd1 && subop <= gcsd_pkg::SUBOP_COMMON_MAX)
								? gcsd_pkg::ST_HANDLED : gcsd_pkg::ST_UNHANDLED;
						end else begin
							hdr.status = gcsd_pkg::ST_ILLEGAL;
						end
					end
					gcsd_pkg::RSUB_SINGLE: begin
						hdr.status = ((rop == gcsd_pkg::RENDER_OP_STATE &&
							subop == gcsd_pkg::SUBOP_SELECT_PIPE) ||
							(rop == gcsd_pkg::RENDER_OP_CTRL &&
							subop == gcsd_pkg::SUBOP_SINGLE_CTRL))
							? gcsd_pkg::ST_HANDLED : gcsd_pkg::ST_ILLEGAL;
						hdr.len_m1 = '0;
					end
					gcsd_pkg::RSUB_RESERVED: begin
						hdr.status = gcsd_pkg::ST_UNKNOWN;
						hdr.len_m1 = gcsd_pkg::IndexW'(1);
					end
					default: begin
						case (rop)
							gcsd_pkg::RENDER_OP_STATE: hdr.status = gcsd_pkg::pipe_known(subop)
								? gcsd_pkg::ST_HANDLED : gcsd_pkg::ST_UNHANDLED;
							gcsd_pkg::RENDER_OP_PRIM: hdr.status = (subop == 8'd0)
								? gcsd_pkg::ST_HANDLED : gcsd_pkg::ST_UNHANDLED;
							gcsd_pkg::RENDER_OP_EXT: hdr.status = (subop == 8'd0)
								? gcsd_pkg::ST_HANDLED : gcsd_pkg::ST_ILLEGAL;
							default: hdr.status = gcsd_pkg::ST_HANDLED;
						endcase
					end
				endcase
			end
			default: begin
				hdr.status = gcsd_pkg::ST_UNKNOWN;
			end
		endcase
	end

endmodule

>>> hw/rtl/gcsd_queue.sv
// ----------------------------------------------------------------------------
// gcsd_queue
// Short queue of decoded words between the front decode and the sequencer.
// ----------------------------------------------------------------------------
module gcsd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  gcsd_pkg::entry_t wr_data,
	output logic             full,
	input  logic             rd,
	output gcsd_pkg::entry_t rd_data,
	output logic             empty
);

	gcsd_pkg::entry_t                  mem_q [gcsd_pkg::QueueDepth];
	logic [gcsd_pkg::QueuePtrW-1:0]    wptr_q;
	logic [gcsd_pkg::QueuePtrW-1:0]    rptr_q;
	logic [gcsd_pkg::QueueCntW-1:0]    count_q;
	logic                              do_wr;
	logic                              do_rd;

	assign full    = (count_q == gcsd_pkg::QueueCntW'(gcsd_pkg::QueueDepth));
	assign empty   = (count_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + gcsd_pkg::QueuePtrW'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + gcsd_pkg::QueuePtrW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + gcsd_pkg::QueueCntW'(1);
				2'b01:   count_q <= count_q - gcsd_pkg::QueueCntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/gcsd_seq.sv
// ----------------------------------------------------------------------------
// gcsd_seq
// Command framing: tracks header/body position and drives the result register.
// ----------------------------------------------------------------------------
module gcsd_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  gcsd_pkg::entry_t            q_data,
	output logic                        q_rd,
	input  logic                        pop,
	output logic                        empty,
	output logic [gcsd_pkg::WordW-1:0]  payload,
	output logic [gcsd_pkg::IndexW-1:0] word_index,
	output logic [2:0]                  cmd_type,
	output logic [1:0]                  cmd_subtype,
	output logic [5:0]                  cmd_opcode,
	output logic [7:0]                  cmd_subopcode,
	output logic [1:0]                  status,
	output logic                        last_word,
	output logic                        batch_end
);

	logic                        out_valid_q;
	logic [gcsd_pkg::IndexW-1:0] remain_q;
	logic [gcsd_pkg::IndexW-1:0] pos_q;
	gcsd_pkg::hdr_t              held_q;
	logic [gcsd_pkg::WordW-1:0]  payload_q;
	logic                        last_q;
	logic                        bend_q;
	logic                        take;
	logic                        is_hdr;

	assign take   = !q_empty && (!out_valid_q || pop);
	assign q_rd   = take;
	assign is_hdr = (remain_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			remain_q    <= '0;
			pos_q       <= '0;
			held_q      <= '0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (is_hdr) begin
					held_q   <= q_data.hdr;
					pos_q    <= '0;
					remain_q <= q_data.hdr.len_m1;
				end else begin
					pos_q    <= pos_q + gcsd_pkg::IndexW'(1);
					remain_q <= remain_q - gcsd_pkg::IndexW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			payload_q <= q_data.word;
			last_q    <= is_hdr ? (q_data.hdr.len_m1 == '0)
				: (remain_q == gcsd_pkg::IndexW'(1));
			bend_q    <= is_hdr && q_data.hdr.batch_end;
		end
	end

	assign empty         = !out_valid_q;
	assign payload       = payload_q;
	assign word_index    = pos_q;
	assign cmd_type      = held_q.cmd_type;
	assign cmd_subtype   = held_q.cmd_subtype;
	assign cmd_opcode    = held_q.cmd_opcode;
	assign cmd_subopcode = held_q.cmd_subopcode;
	assign status        = held_q.status;
	assign last_word     = last_q;
	assign batch_end     = bend_q;

endmodule

>>> hw/rtl/gpu_command_stream_deframer.sv
// ----------------------------------------------------------------------------
// gpu_command_stream_deframer
// Splits a batch-buffer dword stream into tagged command words.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive word and raise push; the word is taken on
//   a clock edge where push is high and full is low.
//   Result side is a queue too: while empty is low the oldest tagged word is
//   on payload and the tag ports; it is taken on an edge with pop high.
//   Every input word gives exactly one result word, in order.
// Path: a pushed word is written into the queue, then moved into the result
//   register when the result side is free, and shows on the result ports.
// Throughput: one word per cycle while pop is held high; the front decode, the
//   four-entry queue and the result register each move one word a cycle.
// Reset: arst_n low empties the queue and the result register and returns the
//   framer to expecting a header.
// Stall: with pop held low the result holds; the queue then fills and full
//   rises after four further words.
// ----------------------------------------------------------------------------
module gpu_command_stream_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [gcsd_pkg::WordW-1:0]  word,
	input  logic                        pop,
	output logic                        empty,
	output logic [gcsd_pkg::WordW-1:0]  payload,
	output logic [gcsd_pkg::IndexW-1:0] word_index,
	output logic [2:0]                  cmd_type,
	output logic [1:0]                  cmd_subtype,
	output logic [5:0]                  cmd_opcode,
	output logic [7:0]                  cmd_subopcode,
	output logic [1:0]                  status,
	output logic                        last_word,
	output logic                        batch_end
);

	gcsd_pkg::hdr_t   dec_hdr;
	gcsd_pkg::entry_t wr_entry;
	gcsd_pkg::entry_t rd_entry;
	logic             q_empty;
	logic             q_rd;

	gcsd_front u_front (
		.word (word),
		.hdr  (dec_hdr)
	);

	assign wr_entry = '{word: word, hdr: dec_hdr};

	gcsd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (push),
		.wr_data (wr_entry),
		.full    (full),
		.rd      (q_rd),
		.rd_data (rd_entry),
		.empty   (q_empty)
	);

	gcsd_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_data        (rd_entry),
		.q_rd          (q_rd),
		.pop           (pop),
		.empty         (empty),
		.payload       (payload),
		.word_index    (word_index),
		.cmd_type      (cmd_type),
		.cmd_subtype   (cmd_subtype),
		.cmd_opcode    (cmd_opcode),
		.cmd_subopcode (cmd_subopcode),
		.status        (status),
		.last_word     (last_word),
		.batch_end     (batch_end)
	);

	// batch end only ever tags an MI header
	a_bend_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && batch_end) |-> (word_index == '0 && cmd_type == gcsd_pkg::TYPE_MI &&
			status == gcsd_pkg::ST_HANDLED))
		else $error("batch end on a non-header word");

	// types other than MI and render decode as unknown
	a_unknown_type: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && cmd_type != gcsd_pkg::TYPE_MI && cmd_type != gcsd_pkg::TYPE_RENDER)
		|-> (status == gcsd_pkg::ST_UNKNOWN && cmd_opcode == '0))
		else $error("unknown type not flagged");

	// a body word follows the previous word of the same command
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(q_rd && !empty && !last_word) |=> (word_index == $past(word_index) + 9'd1))
		else $error("word index did not advance");

	// the framer never pulls from an empty queue
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> !q_empty)
		else $error("read from empty queue");

endmodule
